>>> hw/rtl/bmp_pixel_stream_decoder_assert.svh
// Assertion macros shared by the decoder checker.
`ifndef BMP_PIXEL_STREAM_DECODER_ASSERT_SVH
`define BMP_PIXEL_STREAM_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bmp_pkg.sv
`default_nettype none

package bmp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int STRIDE_W  = DIM_W + 3;
  localparam int TOT_W     = STRIDE_W + DIM_W;
  localparam int CMP_W     = (TOT_W > 32) ? TOT_W : 32;

  localparam int COL_OUT_W = 12;
  localparam int SZ_OUT_W  = 13;

  localparam logic [31:0] HDR_BYTES = 32'd54;
  localparam logic [31:0] HDR_LAST  = 32'd53;
  localparam logic [31:0] MIN_DIB   = 32'd40;
  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [15:0] BPP_24    = 16'd24;
  localparam logic [15:0] BPP_32    = 16'd32;

  localparam logic [5:0] OFS_PIX = 6'd10;
  localparam logic [5:0] OFS_DIB = 6'd14;
  localparam logic [5:0] OFS_WID = 6'd18;
  localparam logic [5:0] OFS_HGT = 6'd22;
  localparam logic [5:0] OFS_PLN = 6'd26;
  localparam logic [5:0] OFS_CMP = 6'd30;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    RSN_NONE    = 3'd0,
    RSN_SHORT   = 3'd1,
    RSN_SIG     = 3'd2,
    RSN_HDR     = 3'd3,
    RSN_FMT     = 3'd4,
    RSN_OVERRUN = 3'd5,
    RSN_BIG     = 3'd6
  } reason_t;

  typedef enum logic [1:0] {
    ST_HDR  = 2'd0,
    ST_BODY = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic    fire;
    logic    restart;
    logic    hdr_store;
    logic    start_body;
    logic    body_step;
    logic    emit;
    kind_t   kind;
    reason_t reason;
  } dp_cmd_t;

  typedef struct packed {
    logic    idx_zero;
    logic    idx_last;
    logic    short_file;
    reason_t reason;
    logic    body_live;
    logic    pixel_byte;
    logic    img_end;
  } dp_status_t;

  typedef struct packed {
    kind_t                 kind;
    reason_t               reason;
    logic [COL_OUT_W-1:0]  column;
    logic [COL_OUT_W-1:0]  row;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [SZ_OUT_W-1:0]   image_width;
    logic [SZ_OUT_W-1:0]   image_height;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bmp_pixel_stream_decoder.sv
// Channel   Direction  tdata                                  tuser
// in_       slave      data_byte                              first_byte
// out_      master     reason .. image_height (80 bits)       kind
// cfg_      write      file_length                            -
//
// One byte is taken per clock while in_tready is high, and finishes in that cycle.
// A result appears in the output register the cycle after its byte.
// in_tready drops only while a result waits and out_tready is low.
// The overrun check uses a stride and size product registered after the bit-depth
// bytes via plane_depth_r, stride_r and total_r, well before the last header byte.
// rst_n is synchronous; after it the parse starts at byte zero.
`default_nettype none

module bmp_pixel_stream_decoder import bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] reason, [14:3] column, [26:15] row, [34:27] red, [42:35] green,
  // [50:43] blue, [63:51] image_width, [76:64] image_height, [79:77] zero
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic       in_fire;
  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;
  logic       out_valid_r;
  result_t    out_res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  bmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_first (in_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  bmp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {3'b000, out_res_r.image_height, out_res_r.image_width,
                       out_res_r.blue, out_res_r.green, out_res_r.red,
                       out_res_r.row, out_res_r.column, out_res_r.reason};

endmodule

`default_nettype wire

>>> hw/rtl/bmp_ctrl.sv
`default_nettype none

module bmp_ctrl import bmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_first,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  state_t phase;
  logic   at_zero;
  logic   at_last;

  assign phase   = in_first ? ST_HDR : state_r;
  assign at_zero = in_first | status.idx_zero;
  assign at_last = !in_first & status.idx_last;

  always_comb begin
    state_nxt = state_r;
    if (in_fire) begin
      unique case (phase)
        ST_HDR: begin
          state_nxt = ST_HDR;
          if (at_zero && status.short_file) begin
            state_nxt = ST_DONE;
          end else if (at_last) begin
            state_nxt = (status.reason != RSN_NONE) ? ST_DONE : ST_BODY;
          end
        end
        ST_BODY: begin
          if (status.body_live && status.img_end) begin
            state_nxt = ST_DONE;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.fire    = in_fire;
    cmd.restart = in_fire & in_first;
    cmd.kind    = KIND_ACCEPT;
    cmd.reason  = RSN_NONE;
    if (in_fire) begin
      unique case (phase)
        ST_HDR: begin
          if (at_zero && status.short_file) begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_REJECT;
            cmd.reason = RSN_SHORT;
          end else begin
            cmd.hdr_store = 1'b1;
            if (at_last) begin
              cmd.emit = 1'b1;
              if (status.reason != RSN_NONE) begin
                cmd.kind   = KIND_REJECT;
                cmd.reason = status.reason;
              end else begin
                cmd.kind       = KIND_ACCEPT;
                cmd.start_body = 1'b1;
              end
            end
          end
        end
        ST_BODY: begin
          if (status.body_live) begin
            cmd.body_step = 1'b1;
            if (status.pixel_byte) begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_PIXEL;
            end
          end
        end
        default: begin
          cmd.emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmp_dp.sv
`default_nettype none

module bmp_dp import bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output dp_status_t  status,
  output result_t     result
);

  function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [5:0] idx,
                                           input logic [5:0] base, input logic [7:0] b);
    logic [5:0]  rel;
    logic [31:0] res;
    rel = idx - base;
    res = word;
    if (idx >= base && idx < base + 6'd4) begin
      res[{rel[1:0], 3'b000} +: 8] = b;
    end
    return res;
  endfunction

  logic [31:0] file_len_r;
  logic [31:0] byte_idx_r,    byte_idx_nxt;
  logic [31:0] pix_start_r,   pix_start_nxt;
  logic [31:0] dib_len_r,     dib_len_nxt;
  logic [31:0] width_word_r,  width_word_nxt;
  logic [31:0] height_word_r, height_word_nxt;
  logic [31:0] plane_depth_r, plane_depth_nxt;
  logic [31:0] compr_r,       compr_nxt;
  logic [15:0] hold_r,        hold_nxt;
  logic [DIM_W-1:0] col_r,    col_nxt;
  logic [DIM_W-1:0] srow_r,   srow_nxt;
  logic [1:0]  bip_r,         bip_nxt;
  logic [1:0]  pad_r,         pad_nxt;

  logic [31:0]         abs_h_r;
  logic                sig_bad_r;
  logic                hdr_bad_r;
  logic                fmt_bad_r;
  logic                big_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [TOT_W-1:0]    total_r;

  logic [31:0]         idx_eff;
  logic [5:0]          hdr_idx;
  logic                hdr_in;
  logic                bpb32;
  logic [DIM_W-1:0]    h_dim;
  logic [DIM_W-1:0]    w_dim;
  logic [DIM_W:0]      col_inc;
  logic [DIM_W:0]      srow_inc;
  logic                col_wrap;
  logic                last_byte;
  logic [1:0]          row_pad;
  logic [DIM_W-1:0]    row_val;
  logic [DIM_W+1:0]    w_mul;
  logic [STRIDE_W-1:0] stride_raw;
  logic [TOT_W-1:0]    prod;
  logic [CMP_W-1:0]    room;
  logic                overrun;

  assign idx_eff   = cmd.restart ? '0 : byte_idx_r;
  assign hdr_idx   = idx_eff[5:0];
  assign hdr_in    = (idx_eff[31:6] == '0);
  assign bpb32     = (plane_depth_r[31:16] == BPP_32);
  assign h_dim     = abs_h_r[DIM_W-1:0];
  assign w_dim     = width_word_r[DIM_W-1:0];
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign srow_inc  = {1'b0, srow_r} + 1'b1;
  assign col_wrap  = (col_inc >= {1'b0, w_dim});
  assign last_byte = bpb32 ? (bip_r == 2'd3) : (bip_r == 2'd2);
  assign row_pad   = bpb32 ? 2'd0 : width_word_r[1:0];
  assign row_val   = height_word_r[31] ? srow_r : (h_dim - DIM_W'(1) - srow_r);

  assign w_mul      = bpb32 ? {w_dim, 2'b00} : ({2'b00, w_dim} + {1'b0, w_dim, 1'b0});
  assign stride_raw = {1'b0, w_mul} + STRIDE_W'(3);
  assign prod       = stride_r * h_dim;
  assign room       = CMP_W'(file_len_r - pix_start_r);
  assign overrun    = (CMP_W'(total_r) > room);

  always_comb begin
    status            = '0;
    status.idx_zero   = (byte_idx_r == '0);
    status.idx_last   = (byte_idx_r == HDR_LAST);
    status.short_file = (file_len_r < HDR_BYTES);
    status.body_live  = (byte_idx_r >= pix_start_r);
    status.pixel_byte = (pad_r == 2'd0) && (bip_r == 2'd2);
    if (pad_r != 2'd0) begin
      status.img_end = (pad_r == 2'd1) && ({1'b0, srow_r} >= {1'b0, h_dim});
    end else begin
      status.img_end = last_byte && col_wrap && (row_pad == 2'd0) &&
                       (srow_inc >= {1'b0, h_dim});
    end
    priority if (file_len_r < HDR_BYTES) begin
      status.reason = RSN_SHORT;
    end else if (sig_bad_r) begin
      status.reason = RSN_SIG;
    end else if (hdr_bad_r || pix_start_r >= file_len_r) begin
      status.reason = RSN_HDR;
    end else if (fmt_bad_r) begin
      status.reason = RSN_FMT;
    end else if (big_r) begin
      status.reason = RSN_BIG;
    end else if (overrun) begin
      status.reason = RSN_OVERRUN;
    end else begin
      status.reason = RSN_NONE;
    end
  end

  always_comb begin
    result        = '0;
    result.kind   = cmd.kind;
    result.reason = cmd.reason;
    unique case (cmd.kind)
      KIND_PIXEL: begin
        result.column = COL_OUT_W'(col_r);
        result.row    = COL_OUT_W'(row_val);
        result.red    = data_byte;
        result.green  = hold_r[15:8];
        result.blue   = hold_r[7:0];
      end
      KIND_ACCEPT: begin
        result.image_width  = SZ_OUT_W'(width_word_r);
        result.image_height = SZ_OUT_W'(abs_h_r);
      end
      default: begin
        result.column = '0;
      end
    endcase
  end

  always_comb begin
    byte_idx_nxt    = byte_idx_r;
    pix_start_nxt   = pix_start_r;
    dib_len_nxt     = dib_len_r;
    width_word_nxt  = width_word_r;
    height_word_nxt = height_word_r;
    plane_depth_nxt = plane_depth_r;
    compr_nxt       = compr_r;
    hold_nxt        = hold_r;
    col_nxt         = col_r;
    srow_nxt        = srow_r;
    bip_nxt         = bip_r;
    pad_nxt         = pad_r;

    if (cmd.fire) begin
      byte_idx_nxt = (&idx_eff) ? idx_eff : idx_eff + 32'd1;
    end

    if (cmd.restart) begin
      pix_start_nxt   = '0;
      dib_len_nxt     = '0;
      width_word_nxt  = '0;
      height_word_nxt = '0;
      plane_depth_nxt = '0;
      compr_nxt       = '0;
      hold_nxt        = '0;
      col_nxt         = '0;
      srow_nxt        = '0;
      bip_nxt         = '0;
      pad_nxt         = '0;
    end

    if (cmd.hdr_store && hdr_in) begin
      if (hdr_idx == 6'd0) begin
        hold_nxt[7:0] = data_byte;
      end else if (hdr_idx == 6'd1) begin
        hold_nxt[15:8] = data_byte;
      end
      pix_start_nxt   = put_lane(pix_start_nxt,   hdr_idx, OFS_PIX, data_byte);
      dib_len_nxt     = put_lane(dib_len_nxt,     hdr_idx, OFS_DIB, data_byte);
      width_word_nxt  = put_lane(width_word_nxt,  hdr_idx, OFS_WID, data_byte);
      height_word_nxt = put_lane(height_word_nxt, hdr_idx, OFS_HGT, data_byte);
      plane_depth_nxt = put_lane(plane_depth_nxt, hdr_idx, OFS_PLN, data_byte);
      compr_nxt       = put_lane(compr_nxt,       hdr_idx, OFS_CMP, data_byte);
    end

    if (cmd.start_body) begin
      col_nxt  = '0;
      srow_nxt = '0;
      bip_nxt  = '0;
      hold_nxt = '0;
      pad_nxt  = '0;
    end

    if (cmd.body_step) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        unique case (bip_r)
          2'd0:    hold_nxt[7:0]  = data_byte;
          2'd1:    hold_nxt[15:8] = data_byte;
          default: hold_nxt       = hold_r;
        endcase
        if (last_byte) begin
          bip_nxt = '0;
          if (col_wrap) begin
            col_nxt  = '0;
            srow_nxt = srow_inc[DIM_W-1:0];
            pad_nxt  = row_pad;
          end else begin
            col_nxt = col_inc[DIM_W-1:0];
          end
        end else begin
          bip_nxt = bip_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r    <= '0;
      byte_idx_r    <= '0;
      pix_start_r   <= '0;
      dib_len_r     <= '0;
      width_word_r  <= '0;
      height_word_r <= '0;
      plane_depth_r <= '0;
      compr_r       <= '0;
      hold_r        <= '0;
      col_r         <= '0;
      srow_r        <= '0;
      bip_r         <= '0;
      pad_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        file_len_r <= cfg_wr_data;
      end
      byte_idx_r    <= byte_idx_nxt;
      pix_start_r   <= pix_start_nxt;
      dib_len_r     <= dib_len_nxt;
      width_word_r  <= width_word_nxt;
      height_word_r <= height_word_nxt;
      plane_depth_r <= plane_depth_nxt;
      compr_r       <= compr_nxt;
      hold_r        <= hold_nxt;
      col_r         <= col_nxt;
      srow_r        <= srow_nxt;
      bip_r         <= bip_nxt;
      pad_r         <= pad_nxt;
    end
  end

  // Header check terms, refreshed every cycle from the stored fields
  always_ff @(posedge clk) begin
    abs_h_r   <= height_word_r[31] ? (32'd0 - height_word_r) : height_word_r;
    sig_bad_r <= (hold_r[7:0] != SIG_B) || (hold_r[15:8] != SIG_M);
    hdr_bad_r <= (dib_len_r < MIN_DIB) || (pix_start_r < HDR_BYTES);
    fmt_bad_r <= width_word_r[31] || (width_word_r == '0) || (height_word_r == '0) ||
                 (plane_depth_r[15:0] != 16'd1) ||
                 ((plane_depth_r[31:16] != BPP_24) && (plane_depth_r[31:16] != BPP_32)) ||
                 (compr_r != '0);
    big_r     <= (width_word_r > 32'(MAX_DIM)) || (abs_h_r > 32'(MAX_DIM));
    stride_r  <= {stride_raw[STRIDE_W-1:2], 2'b00};
    total_r   <= prod;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmp_checker.sv
`default_nettype none

`include "bmp_pixel_stream_decoder_assert.svh"

module bmp_checker import bmp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `BMP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `BMP_ASSERT_SAME(a_ready_empty, !out_tvalid, in_tready, "input stalled with empty output")
  `BMP_ASSERT_SAME(a_rise_src, $rose(out_tvalid), $past(in_tvalid && in_tready), "result without input transfer")
  `BMP_ASSERT_SAME(a_pixel_zero, out_tvalid && (out_tuser == KIND_PIXEL), (out_tdata[2:0] == 3'd0) && (out_tdata[76:51] == 26'd0), "pixel carries reason or size")
  `BMP_ASSERT_SAME(a_reject_zero, out_tvalid && (out_tuser == KIND_REJECT), out_tdata[76:3] == 74'd0, "rejection carries pixel or size")

endmodule

bind bmp_pixel_stream_decoder bmp_checker u_bmp_checker (.*);

`default_nettype wire
